[rtl/core/terminal_line_editor_assert.svh]
// ----------------------------------------------------------------------------
// terminal line editor assertion macros
// shared property wrappers, clocked on aclk with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// same-cycle implication
`define TLE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("terminal_line_editor: same-cycle check failed");

// next-cycle implication
`define TLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("terminal_line_editor: next-cycle check failed");

`endif

[rtl/core/tle_pkg.sv]
// ----------------------------------------------------------------------------
// tle_pkg
// shared constants and types of the terminal line editor
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int COUNT_W    = $clog2(LINE_DEPTH);
    localparam int CAP_W      = 6;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(32);
    localparam logic             REG_LINE_CAP = 1'b0;

    typedef struct packed {
        logic       channel;
        logic [7:0] out_byte;
        logic       last;
    } res_t;

    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [COUNT_W-1:0] addr;
        logic [7:0]         wr_data;
    } mem_req_t;

endpackage

[rtl/core/tle_cfg.sv]
// ----------------------------------------------------------------------------
// tle_cfg
// apb register port holding the line capacity
// ----------------------------------------------------------------------------
module tle_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tle_pkg::ADDR_W-1:0]  paddr,
    input  logic [tle_pkg::DATA_W-1:0]  pwdata,
    output logic [tle_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [tle_pkg::CAP_W-1:0]   line_capacity
);
    import tle_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             wr_hit;

    assign pready = 1'b1;
    // register index is paddr[2]; low bits ignored
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_LINE_CAP);

    always_comb begin
        cap_next = cap_reg;
        if (wr_hit) begin
            cap_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else begin
            cap_reg <= cap_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LINE_CAP) begin
            prdata = DATA_W'(cap_reg);
        end
    end

    assign line_capacity = cap_reg;

endmodule

[rtl/core/tle_line_mem.sv]
// ----------------------------------------------------------------------------
// tle_line_mem
// line store: single-port synchronous ram with a registered read
// ----------------------------------------------------------------------------
module tle_line_mem (
    input  logic               aclk,
    input  tle_pkg::mem_req_t  mem_req,
    output logic [7:0]         rd_data
);
    import tle_pkg::*;

    logic [7:0] mem [LINE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en) begin
            rd_data_reg <= mem[mem_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/tle_out_reg.sv]
// ----------------------------------------------------------------------------
// tle_out_reg
// one-entry output register between the sequencer and the result channel
// ----------------------------------------------------------------------------
module tle_out_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tle_pkg::res_t  push_data,
    output logic           out_free,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_channel,
    output logic [7:0]     m_out_byte,
    output logic           m_last
);
    import tle_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= push_data;
        end
    end

    assign m_valid    = valid_reg;
    assign m_channel  = data_reg.channel;
    assign m_out_byte = data_reg.out_byte;
    assign m_last     = data_reg.last;

endmodule

[rtl/core/tle_seq.sv]
// ----------------------------------------------------------------------------
// tle_seq
// line-ending normalization, edit decode and result sequencing
// ----------------------------------------------------------------------------
module tle_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_rx_byte,
    input  logic [tle_pkg::CAP_W-1:0]  line_capacity,
    output tle_pkg::mem_req_t          mem_req,
    input  logic [7:0]                 rd_data,
    input  logic                       out_free,
    output logic                       push,
    output tle_pkg::res_t              push_data
);
    import tle_pkg::*;

    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_ECHO       = 3'd1;
    localparam logic [2:0] ST_FLUSH_RD   = 3'd2;
    localparam logic [2:0] ST_FLUSH_DATA = 3'd3;
    localparam logic [2:0] ST_TERM       = 3'd4;

    localparam logic [1:0] K_CHAR    = 2'd0;
    localparam logic [1:0] K_BELL    = 2'd1;
    localparam logic [1:0] K_ERASE   = 2'd2;
    localparam logic [1:0] K_NEWLINE = 2'd3;

    logic [2:0]         state_reg,  state_next;
    logic               cr_reg,     cr_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [COUNT_W-1:0] flen_reg,   flen_next;
    logic [COUNT_W-1:0] idx_reg,    idx_next;
    logic [1:0]         kind_reg,   kind_next;
    logic [1:0]         step_reg,   step_next;
    logic [7:0]         char_reg,   char_next;

    logic               accept;
    logic [7:0]         c;
    logic               drop;
    logic               cr_in;
    logic [CAP_W-1:0]   limit;
    logic [CAP_W:0]     cnt_plus;
    logic [COUNT_W:0]   idx_plus;
    logic [7:0]         echo_byte;
    logic               echo_done;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // cr becomes lf, lf right after cr is dropped, esc only clears the flag
    always_comb begin
        c     = s_rx_byte;
        drop  = 1'b0;
        cr_in = 1'b0;
        if (s_rx_byte == CH_CR) begin
            c     = CH_LF;
            cr_in = 1'b1;
        end else if (cr_reg && (s_rx_byte == CH_LF)) begin
            drop = 1'b1;
        end else if (s_rx_byte == CH_ESC) begin
            drop = 1'b1;
        end
    end

    assign limit    = (line_capacity > CAP_W'(LINE_DEPTH)) ? CAP_W'(LINE_DEPTH) : line_capacity;
    assign cnt_plus = (CAP_W+1)'(count_reg) + (CAP_W+1)'(1);
    assign idx_plus = (COUNT_W+1)'(idx_reg) + (COUNT_W+1)'(1);

    always_comb begin
        echo_byte = CH_BEL;
        echo_done = 1'b1;
        unique case (kind_reg)
            K_CHAR: begin
                echo_byte = char_reg;
            end
            K_BELL: begin
                echo_byte = CH_BEL;
            end
            K_ERASE: begin
                echo_byte = (step_reg == 2'd1) ? CH_SPACE : CH_BS;
                echo_done = (step_reg == 2'd2);
            end
            K_NEWLINE: begin
                echo_byte = (step_reg == 2'd0) ? CH_CR : CH_LF;
                echo_done = (step_reg == 2'd1);
            end
            default: begin
                echo_byte = CH_BEL;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cr_next    = cr_reg;
        count_next = count_reg;
        flen_next  = flen_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        step_next  = step_reg;
        char_next  = char_reg;
        mem_req    = '0;
        push       = 1'b0;
        push_data  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cr_next = cr_in;
                    if (!drop) begin
                        state_next = ST_ECHO;
                        step_next  = 2'd0;
                        char_next  = c;
                        if (c == CH_LF) begin
                            kind_next  = K_NEWLINE;
                            flen_next  = count_reg;
                            count_next = '0;
                        end else if ((c == CH_BS) || (c == CH_DEL)) begin
                            if (count_reg != '0) begin
                                kind_next  = K_ERASE;
                                count_next = count_reg - COUNT_W'(1);
                            end else begin
                                kind_next = K_BELL;
                            end
                        end else if (cnt_plus < (CAP_W+1)'(limit)) begin
                            kind_next       = K_CHAR;
                            mem_req.wr_en   = 1'b1;
                            mem_req.addr    = count_reg;
                            mem_req.wr_data = c;
                            count_next      = cnt_plus[COUNT_W-1:0];
                        end else begin
                            kind_next = K_BELL;
                        end
                    end
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    push               = 1'b1;
                    push_data.out_byte = echo_byte;
                    if (echo_done) begin
                        if (kind_reg != K_NEWLINE) begin
                            state_next = ST_IDLE;
                        end else if (flen_reg == '0) begin
                            state_next = ST_TERM;
                        end else begin
                            state_next = ST_FLUSH_RD;
                            idx_next   = '0;
                        end
                    end else begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            ST_FLUSH_RD: begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = idx_reg;
                state_next    = ST_FLUSH_DATA;
            end
            ST_FLUSH_DATA: begin
                if (out_free) begin
                    push               = 1'b1;
                    push_data.channel  = 1'b1;
                    push_data.out_byte = rd_data;
                    if (idx_plus < (COUNT_W+1)'(flen_reg)) begin
                        idx_next   = idx_plus[COUNT_W-1:0];
                        state_next = ST_FLUSH_RD;
                    end else begin
                        state_next = ST_TERM;
                    end
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    push              = 1'b1;
                    push_data.channel = 1'b1;
                    push_data.last    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cr_reg    <= 1'b0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            cr_reg    <= cr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        flen_reg <= flen_next;
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        step_reg <= step_next;
        char_reg <= char_next;
    end

endmodule

[rtl/core/terminal_line_editor.sv]
// ----------------------------------------------------------------------------
// terminal_line_editor
// canonical tty line editor: echo, erase, line store and line flush
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_rx_byte
//   m_        out        m_valid/m_ready    m_channel, m_out_byte, m_last
//   apb       in         psel/penable       line_capacity at byte address 0
//
// one transaction is taken at a time; the decode cycle also writes the stored byte
// echo items leave one per cycle while the output register is free (one to three per transaction)
// a line flush reads the ram once per stored byte, in a read state then a data state,
// as the single port's read is registered; one terminator follows on the line channel
// esc and an lf after cr give no result and s_ready stays high
// reset is synchronous; m_ready low holds the output register and stalls the flush
// ----------------------------------------------------------------------------
`include "terminal_line_editor_assert.svh"

module terminal_line_editor (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_channel,
    output logic [7:0]                  m_out_byte,
    output logic                        m_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tle_pkg::ADDR_W-1:0]  paddr,
    input  logic [tle_pkg::DATA_W-1:0]  pwdata,
    output logic [tle_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import tle_pkg::*;

    logic [CAP_W-1:0] line_capacity;
    mem_req_t         mem_req;
    logic [7:0]       rd_data;
    logic             out_free;
    logic             push;
    res_t             push_data;
    logic [CAP_W:0]   wr_addr_inc;

    tle_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .line_capacity (line_capacity)
    );

    tle_line_mem u_mem (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    tle_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .line_capacity (line_capacity),
        .mem_req       (mem_req),
        .rd_data       (rd_data),
        .out_free      (out_free),
        .push          (push),
        .push_data     (push_data)
    );

    tle_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_channel  (m_channel),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

    assign wr_addr_inc = (CAP_W+1)'(mem_req.addr) + (CAP_W+1)'(1);

    // ram writes happen only in the decode cycle of an accepted transaction
    `TLE_ASSERT_SAME(a_wr_on_accept, mem_req.wr_en, s_valid && s_ready)
    // no transaction is taken while the flush reads the line ram
    `TLE_ASSERT_SAME(a_rd_blocks_input, mem_req.rd_en, !s_ready)
    // a stored byte always stays below the capacity limit
    `TLE_ASSERT_SAME(a_wr_below_cap, mem_req.wr_en, wr_addr_inc < (CAP_W+1)'(line_capacity))
    // the terminator belongs to the line channel
    `TLE_ASSERT_SAME(a_last_on_line, m_valid && m_last, m_channel && (m_out_byte == 8'h00))

endmodule
